### hw/rtl/four_channel_fir_filter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-channel FIR filter
// Each macro expands to a clocked concurrent assertion on clk, or to nothing
// when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_FIR_FILTER_TOP_MACROS_SVH
`define FOUR_CHANNEL_FIR_FILTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Checked outside reset only
`define FCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included
`define FCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCF_ASSERT(lbl, prop, msg)
`define FCF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg
// Shared constants, types and controller states of the four-channel FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fcf_pkg;

  // Filter geometry
  localparam int TAPS      = 32;
  localparam int CHANNELS  = 4;
  localparam int IN_LANES  = 4;
  localparam int PTR_W     = (TAPS > 1) ? $clog2(TAPS) : 1;

  // Field widths
  localparam int SMP_W     = 10;
  localparam int COEF_W    = 16;
  localparam int CH_W      = 2;
  localparam int TAP_IDX_W = 5;
  localparam int OUT_W     = 16;
  localparam int FRAC_BITS = 15;

  // Product of a signed weight and an unsigned sample (sample gets a zero sign bit)
  localparam int PROD_W    = COEF_W + SMP_W + 1;
  // Sum of TAPS products plus headroom so bits [FRAC_BITS+OUT_W-1:FRAC_BITS] exist
  localparam int ACC_W     = PROD_W + PTR_W + 4;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Controls broadcast from the sequencer to every lane
  typedef struct packed {
    logic             smp_we;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] coef_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             acc_clr;
  } ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/four_channel_fir_filter_top.sv
// ----------------------------------------------------------------------------
// four_channel_fir_filter_top
// Four-lane FIR filter over 10-bit samples with per-channel Q15 tap weights.
// ----------------------------------------------------------------------------
// Input (in_valid/in_ready): a weight write (operation = 1: channel,
//   tap_index, weight_value) or a sample set (operation = 0: sample_ch0..3).
//   A weight write is taken while idle and gives no result. A sample set
//   gives one result transfer on out_valid/out_ready: the raw samples and
//   each channel's filter output.
// After a sample transfer the lanes read all TAPS taps in turn, then the
//   last multiply and accumulate complete (ST_DRAIN) and the output
//   register is loaded (ST_FINISH), which raises out_valid.
// A new sample set is taken only in ST_IDLE; in_ready is low while a set
//   is being filtered and until its result is loaded.
// Reset clears the write pointer, out_valid and the valid bits of both
//   memories, so all history and weights read as zero.
// A stalled receiver holds the result in the output register; the next set
//   can be taken meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "four_channel_fir_filter_top_macros.svh"

module four_channel_fir_filter_top (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 operation,
  input  wire         [fcf_pkg::SMP_W-1:0]    sample_ch0,
  input  wire         [fcf_pkg::SMP_W-1:0]    sample_ch1,
  input  wire         [fcf_pkg::SMP_W-1:0]    sample_ch2,
  input  wire         [fcf_pkg::SMP_W-1:0]    sample_ch3,
  input  wire         [fcf_pkg::CH_W-1:0]     channel,
  input  wire         [fcf_pkg::TAP_IDX_W-1:0] tap_index,
  input  wire  signed [fcf_pkg::COEF_W-1:0]   weight_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic        [fcf_pkg::SMP_W-1:0]    raw_ch0,
  output logic        [fcf_pkg::SMP_W-1:0]    raw_ch1,
  output logic        [fcf_pkg::SMP_W-1:0]    raw_ch2,
  output logic        [fcf_pkg::SMP_W-1:0]    raw_ch3,
  output logic signed [fcf_pkg::OUT_W-1:0]    filtered_ch0,
  output logic signed [fcf_pkg::OUT_W-1:0]    filtered_ch1,
  output logic signed [fcf_pkg::OUT_W-1:0]    filtered_ch2,
  output logic signed [fcf_pkg::OUT_W-1:0]    filtered_ch3
);

  localparam logic [fcf_pkg::PTR_W-1:0] LAST_TAP = fcf_pkg::PTR_W'(fcf_pkg::TAPS - 1);

  fcf_pkg::state_t                   state;
  fcf_pkg::state_t                   state_next;
  fcf_pkg::ctrl_t                    ctrl;

  logic [fcf_pkg::PTR_W-1:0]         wp;
  logic [fcf_pkg::PTR_W-1:0]         rd_addr;
  logic [fcf_pkg::PTR_W-1:0]         cnt;
  logic                              drain;
  logic                              smp_xfer;
  logic                              coef_xfer;
  logic                              tap_ok;
  logic                              load;

  logic        [fcf_pkg::SMP_W-1:0]  smp_in   [fcf_pkg::IN_LANES];
  logic        [fcf_pkg::SMP_W-1:0]  raw_hold [fcf_pkg::IN_LANES];
  logic        [fcf_pkg::SMP_W-1:0]  raw_out  [fcf_pkg::IN_LANES];
  logic signed [fcf_pkg::OUT_W-1:0]  lane_out [fcf_pkg::IN_LANES];
  logic signed [fcf_pkg::OUT_W-1:0]  filt_out [fcf_pkg::IN_LANES];
  logic        [fcf_pkg::CHANNELS-1:0] coef_sel;

  assign smp_in[0] = sample_ch0;
  assign smp_in[1] = sample_ch1;
  assign smp_in[2] = sample_ch2;
  assign smp_in[3] = sample_ch3;

  // Transfer decode
  assign smp_xfer  = in_valid && in_ready && (operation == fcf_pkg::OP_SAMPLE);
  assign coef_xfer = in_valid && in_ready && (operation == fcf_pkg::OP_COEF);
  assign tap_ok    = 32'(tap_index) < 32'(fcf_pkg::TAPS);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fcf_pkg::ST_IDLE: begin
        if (in_valid && (operation == fcf_pkg::OP_SAMPLE)) begin
          state_next = fcf_pkg::ST_RUN;
        end
      end
      fcf_pkg::ST_RUN: begin
        if (cnt == LAST_TAP) begin
          state_next = fcf_pkg::ST_DRAIN;
        end
      end
      fcf_pkg::ST_DRAIN: begin
        if (drain) begin
          state_next = fcf_pkg::ST_FINISH;
        end
      end
      fcf_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = fcf_pkg::ST_IDLE;
        end
      end
      default: state_next = fcf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready       = 1'b0;
    load           = 1'b0;
    ctrl.smp_we    = 1'b0;
    ctrl.rd_en     = 1'b0;
    ctrl.acc_clr   = 1'b0;
    ctrl.wr_addr   = wp;
    ctrl.rd_addr   = rd_addr;
    ctrl.coef_addr = fcf_pkg::PTR_W'(tap_index);
    case (state)
      fcf_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.smp_we  = in_valid && (operation == fcf_pkg::OP_SAMPLE);
        ctrl.acc_clr = in_valid && (operation == fcf_pkg::OP_SAMPLE);
      end
      fcf_pkg::ST_RUN: begin
        ctrl.rd_en     = 1'b1;
        // weights are read by tap number during the walk
        ctrl.coef_addr = cnt;
      end
      fcf_pkg::ST_DRAIN: begin
      end
      fcf_pkg::ST_FINISH: begin
        load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Write pointer, tap walk and drain counter
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rd_addr <= '0;
      cnt     <= '0;
      drain   <= 1'b0;
    end else begin
      if (smp_xfer) begin
        wp      <= (wp == LAST_TAP) ? '0 : wp + 1'b1;
        rd_addr <= wp;
        cnt     <= '0;
        drain   <= 1'b0;
      end else if (state == fcf_pkg::ST_RUN) begin
        cnt     <= cnt + 1'b1;
        rd_addr <= (rd_addr == '0) ? LAST_TAP : rd_addr - 1'b1;
      end else if (state == fcf_pkg::ST_DRAIN) begin
        drain   <= ~drain;
      end
    end
  end

  // Raw samples held until the result is loaded
  always_ff @(posedge clk) begin
    if (smp_xfer) begin
      for (int i = 0; i < fcf_pkg::IN_LANES; i++) begin
        raw_hold[i] <= smp_in[i];
      end
    end
  end

  // Lanes; channels past CHANNELS report zero
  for (genvar c = 0; c < fcf_pkg::IN_LANES; c++) begin : g_lane
    if (c < fcf_pkg::CHANNELS) begin : g_on
      assign coef_sel[c] = coef_xfer && tap_ok && (channel == fcf_pkg::CH_W'(c));

      fcf_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .coef_sel (coef_sel[c]),
        .sample   (smp_in[c]),
        .weight   (weight_value),
        .filtered (lane_out[c])
      );
    end else begin : g_off
      assign lane_out[c] = '0;
    end
  end

  // Output register (merge of all lanes)
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < fcf_pkg::IN_LANES; i++) begin
        raw_out[i]  <= (i < fcf_pkg::CHANNELS) ? raw_hold[i] : '0;
        filt_out[i] <= lane_out[i];
      end
    end
  end

  assign raw_ch0      = raw_out[0];
  assign raw_ch1      = raw_out[1];
  assign raw_ch2      = raw_out[2];
  assign raw_ch3      = raw_out[3];
  assign filtered_ch0 = filt_out[0];
  assign filtered_ch1 = filt_out[1];
  assign filtered_ch2 = filt_out[2];
  assign filtered_ch3 = filt_out[3];

  // Checks
  `FCF_ASSERT(a_load_from_finish, $rose(out_valid) |-> $past(state) == fcf_pkg::ST_FINISH, "result loaded outside finish")
  `FCF_ASSERT(a_sample_starts_walk, smp_xfer |=> state == fcf_pkg::ST_RUN && rd_addr == $past(wp), "tap walk not started at newest slot")
  `FCF_ASSERT(a_coef_stays_idle, coef_xfer |=> state == fcf_pkg::ST_IDLE, "weight write left idle")
  `FCF_ASSERT(a_wp_hold, !smp_xfer |=> $stable(wp), "write pointer moved without a sample transfer")
  `FCF_ASSERT_ALWAYS(a_ready_idle_only, in_ready |-> !out_valid || state == fcf_pkg::ST_IDLE, "input taken while busy")

endmodule

`default_nettype wire

### hw/rtl/fcf_lane.sv
// ----------------------------------------------------------------------------
// fcf_lane
// One channel: sample history and tap weight memories plus a pipelined
// multiply-accumulate that takes one tap per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcf_lane (
  input  wire                                  clk,
  input  wire                                  rst,
  input  fcf_pkg::ctrl_t                       ctrl,
  input  wire                                  coef_sel,
  input  wire         [fcf_pkg::SMP_W-1:0]     sample,
  input  wire  signed [fcf_pkg::COEF_W-1:0]    weight,
  output logic signed [fcf_pkg::OUT_W-1:0]     filtered
);

  // Memories and their per-entry valid bits (unwritten entries read as zero)
  logic        [fcf_pkg::SMP_W-1:0]  hist_mem [fcf_pkg::TAPS];
  logic signed [fcf_pkg::COEF_W-1:0] coef_mem [fcf_pkg::TAPS];
  logic        [fcf_pkg::TAPS-1:0]   hist_vld;
  logic        [fcf_pkg::TAPS-1:0]   coef_vld;

  // Read stage
  logic        [fcf_pkg::SMP_W-1:0]  hist_rd;
  logic signed [fcf_pkg::COEF_W-1:0] coef_rd;
  logic                              hist_rd_ok;
  logic                              coef_rd_ok;
  logic                              rd_vld;

  // Multiply and accumulate stages
  logic        [fcf_pkg::SMP_W-1:0]  smp_op;
  logic signed [fcf_pkg::COEF_W-1:0] coef_op;
  logic signed [fcf_pkg::PROD_W-1:0] prod;
  logic                              mul_vld;
  logic signed [fcf_pkg::ACC_W-1:0]  acc;

  // Memory writes
  always_ff @(posedge clk) begin
    if (ctrl.smp_we) begin
      hist_mem[ctrl.wr_addr] <= sample;
    end
    if (coef_sel) begin
      coef_mem[ctrl.coef_addr] <= weight;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      coef_vld <= '0;
    end else begin
      if (ctrl.smp_we) begin
        hist_vld[ctrl.wr_addr] <= 1'b1;
      end
      if (coef_sel) begin
        coef_vld[ctrl.coef_addr] <= 1'b1;
      end
    end
  end

  // Registered reads: history walks back from the newest slot, weights by tap
  always_ff @(posedge clk) begin
    hist_rd    <= hist_mem[ctrl.rd_addr];
    coef_rd    <= coef_mem[ctrl.coef_addr];
    hist_rd_ok <= hist_vld[ctrl.rd_addr];
    coef_rd_ok <= coef_vld[ctrl.coef_addr];
  end

  assign smp_op  = hist_rd_ok ? hist_rd : '0;
  assign coef_op = coef_rd_ok ? coef_rd : '0;

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      rd_vld  <= ctrl.rd_en;
      mul_vld <= rd_vld;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    prod <= coef_op * $signed({1'b0, smp_op});
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (mul_vld) begin
      acc <= acc + {{(fcf_pkg::ACC_W - fcf_pkg::PROD_W){prod[fcf_pkg::PROD_W-1]}}, prod};
    end
  end

  // Shift by the fraction bits and wrap to the output width
  assign filtered = acc[fcf_pkg::FRAC_BITS + fcf_pkg::OUT_W - 1 : fcf_pkg::FRAC_BITS];

endmodule

`default_nettype wire
